FILE: rtl/pds_pkg.sv
// pds_pkg: shared types of the pairwise distance sorter
// controller state, command and status groups; no dependencies
`default_nettype none
package pds_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN_RD,
    ST_GEN_SQ,
    ST_GEN_WR,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_FETCH,
    ST_ROOT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic rd_pair;
    logic sq_step;
    logic pair_wr;
    logic scan_clr;
    logic scan_run;
    logic fetch;
    logic root_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic run_go;
    logic ax_last;
    logic gen_last;
    logic scan_done;
    logic root_last;
    logic emit_last;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/pds_datapath.sv
// pds_datapath: point store, distance unit, pair store, max scan and serial root
// depends on pds_pkg
`default_nettype none
module pds_datapath import pds_pkg::*; #(
  parameter int MAX_POINTS = 8,
  parameter int COORD_BITS = 11
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire logic [COORD_BITS-1:0]        coord_x_i,
  input  wire logic [COORD_BITS-1:0]        coord_y_i,
  input  wire logic [COORD_BITS-1:0]        coord_z_i,
  input  wire logic                         last_point_i,
  input  wire cmd_t                         cmd_i,
  output sts_t                              sts_o,
  output logic                              result_valid_o,
  output logic [COORD_BITS-1:0]             first_x_o,
  output logic [COORD_BITS-1:0]             first_y_o,
  output logic [COORD_BITS-1:0]             first_z_o,
  output logic [COORD_BITS-1:0]             second_x_o,
  output logic [COORD_BITS-1:0]             second_y_o,
  output logic [COORD_BITS-1:0]             second_z_o,
  output logic [2*COORD_BITS+1:0]           dist_squared_o,
  output logic [COORD_BITS+8:0]             distance_fixed_o,
  output logic                              last_pair_o
);

  localparam int C         = COORD_BITS;
  localparam int PAIRS     = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int PT_W      = $clog2(MAX_POINTS);
  localparam int PN_W      = $clog2(MAX_POINTS + 1);
  localparam int PA_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int PC_W      = $clog2(PAIRS + 1);
  localparam int DIST_BITS = 2 * C + 2;
  localparam int ROOT_BITS = C + 9;
  localparam int RAD_W     = 2 * ROOT_BITS;
  localparam int RC_W      = $clog2(ROOT_BITS);
  localparam int PE_W      = DIST_BITS + 2 * PT_W;

  // point store
  logic [3*C-1:0] pt_mem [MAX_POINTS];
  logic [3*C-1:0] rd_a_q, rd_b_q;
  logic [PN_W-1:0] cnt_q, n_q, cnt_nx;
  logic            full;
  logic [PT_W-1:0] addr_a, addr_b;

  // pair generation
  logic [PT_W-1:0] gi_q, gj_q;
  logic [1:0]      ax_q;
  logic [DIST_BITS-1:0] acc_q;
  logic signed [C:0] da, db, diff;
  logic signed [DIST_BITS-1:0] prod;

  // pair store and scan
  logic [PE_W-1:0] pair_mem [PAIRS];
  logic [PE_W-1:0] pm_rd_q;
  logic [PC_W-1:0] pc_q, sk_q, ec_q;
  logic [PA_W-1:0] sa_q, best_a_q;
  logic            sv_q, bv_q;
  logic [DIST_BITS-1:0] best_d_q, sc_d;
  logic [PT_W-1:0] best_i_q, best_j_q;
  logic [PAIRS-1:0] em_q;

  // root
  logic [RAD_W-1:0]       rad_q;
  logic [ROOT_BITS+1:0]   rem_q, rem_sh, trial;
  logic [ROOT_BITS-1:0]   q_q;
  logic [RC_W-1:0]        rc_q;

  assign full   = (cnt_q >= PN_W'(MAX_POINTS));
  assign cnt_nx = full ? cnt_q : cnt_q + PN_W'(1);
  assign addr_a = cmd_i.fetch ? best_i_q : gi_q;
  assign addr_b = cmd_i.fetch ? best_j_q : gj_q;

  always_ff @(posedge clk_i) begin
    if (load_i && !full) begin
      pt_mem[cnt_q[PT_W-1:0]] <= {coord_x_i, coord_y_i, coord_z_i};
    end
    if (cmd_i.rd_pair || cmd_i.fetch) begin
      rd_a_q <= pt_mem[addr_a];
      rd_b_q <= pt_mem[addr_b];
    end
  end

  always_comb begin
    case (ax_q)
      2'd0: begin
        da = $signed({rd_a_q[3*C-1], rd_a_q[3*C-1:2*C]});
        db = $signed({rd_b_q[3*C-1], rd_b_q[3*C-1:2*C]});
      end
      2'd1: begin
        da = $signed({rd_a_q[2*C-1], rd_a_q[2*C-1:C]});
        db = $signed({rd_b_q[2*C-1], rd_b_q[2*C-1:C]});
      end
      default: begin
        da = $signed({rd_a_q[C-1], rd_a_q[C-1:0]});
        db = $signed({rd_b_q[C-1], rd_b_q[C-1:0]});
      end
    endcase
    diff = da - db;
    prod = diff * diff;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pair_wr) begin
      pair_mem[pc_q[PA_W-1:0]] <= {acc_q, gi_q, gj_q};
    end
    if (cmd_i.scan_run && (sk_q < pc_q)) begin
      pm_rd_q <= pair_mem[sk_q[PA_W-1:0]];
      sa_q    <= sk_q[PA_W-1:0];
    end
  end

  assign sc_d = pm_rd_q[PE_W-1:2*PT_W];

  // serial square root step, one result bit a cycle
  assign rem_sh = {rem_q[ROOT_BITS-1:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial  = {q_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      n_q   <= '0;
      gi_q  <= '0;
      gj_q  <= '0;
      ax_q  <= '0;
      pc_q  <= '0;
      sk_q  <= '0;
      ec_q  <= '0;
      sv_q  <= 1'b0;
      bv_q  <= 1'b0;
      em_q  <= '0;
      rc_q  <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
      if (load_i) begin
        if (last_point_i) begin
          cnt_q <= '0;
          n_q   <= cnt_nx;
          gi_q  <= '0;
          gj_q  <= PT_W'(1);
          pc_q  <= '0;
          ec_q  <= '0;
          em_q  <= '0;
        end else begin
          cnt_q <= cnt_nx;
        end
      end
      if (cmd_i.rd_pair) ax_q <= '0;
      if (cmd_i.sq_step) ax_q <= ax_q + 2'd1;
      if (cmd_i.pair_wr) begin
        pc_q <= pc_q + PC_W'(1);
        if (PN_W'(gj_q) == n_q - PN_W'(1)) begin
          gi_q <= gi_q + PT_W'(1);
          gj_q <= gi_q + PT_W'(2);
        end else begin
          gj_q <= gj_q + PT_W'(1);
        end
      end
      if (cmd_i.scan_clr) begin
        sk_q <= '0;
        sv_q <= 1'b0;
        bv_q <= 1'b0;
      end
      if (cmd_i.scan_run) begin
        sv_q <= (sk_q < pc_q);
        if (sk_q < pc_q) sk_q <= sk_q + PC_W'(1);
        if (sv_q && !em_q[sa_q] && (!bv_q || sc_d > best_d_q)) bv_q <= 1'b1;
      end
      if (cmd_i.fetch) rc_q <= '0;
      if (cmd_i.root_step) rc_q <= rc_q + RC_W'(1);
      if (cmd_i.emit) begin
        em_q[best_a_q] <= 1'b1;
        ec_q <= ec_q + PC_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_pair) acc_q <= '0;
    if (cmd_i.sq_step) acc_q <= acc_q + DIST_BITS'($unsigned(prod));
    if (cmd_i.scan_run && sv_q && !em_q[sa_q] && (!bv_q || sc_d > best_d_q)) begin
      best_d_q <= sc_d;
      best_a_q <= sa_q;
      best_i_q <= pm_rd_q[2*PT_W-1:PT_W];
      best_j_q <= pm_rd_q[PT_W-1:0];
    end
    if (cmd_i.fetch) begin
      rad_q <= {best_d_q, 16'b0};
      rem_q <= '0;
      q_q   <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial;
        q_q   <= {q_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        q_q   <= {q_q[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      first_x_o        <= rd_a_q[3*C-1:2*C];
      first_y_o        <= rd_a_q[2*C-1:C];
      first_z_o        <= rd_a_q[C-1:0];
      second_x_o       <= rd_b_q[3*C-1:2*C];
      second_y_o       <= rd_b_q[2*C-1:C];
      second_z_o       <= rd_b_q[C-1:0];
      dist_squared_o   <= best_d_q;
      distance_fixed_o <= q_q;
      last_pair_o      <= (ec_q + PC_W'(1) == pc_q);
    end
  end

  always_comb begin
    sts_o.run_go    = load_i && last_point_i && (cnt_nx >= PN_W'(2));
    sts_o.ax_last   = (ax_q == 2'd2);
    sts_o.gen_last  = (PN_W'(gi_q) == n_q - PN_W'(2)) && (PN_W'(gj_q) == n_q - PN_W'(1));
    sts_o.scan_done = (sk_q == pc_q) && !sv_q;
    sts_o.root_last = (rc_q == RC_W'(ROOT_BITS - 1));
    sts_o.emit_last = (ec_q + PC_W'(1) == pc_q);
  end

endmodule
`default_nettype wire

FILE: rtl/pds_controller.sv
// pds_controller: sequencing state machine of the pairwise distance sorter
// depends on pds_pkg
`default_nettype none
module pds_controller import pds_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (sts_i.run_go) state_d = ST_GEN_RD;
      ST_GEN_RD:    state_d = ST_GEN_SQ;
      ST_GEN_SQ:    if (sts_i.ax_last) state_d = ST_GEN_WR;
      ST_GEN_WR:    state_d = sts_i.gen_last ? ST_SCAN_INIT : ST_GEN_RD;
      ST_SCAN_INIT: state_d = ST_SCAN;
      ST_SCAN:      if (sts_i.scan_done) state_d = ST_FETCH;
      ST_FETCH:     state_d = ST_ROOT;
      ST_ROOT:      if (sts_i.root_last) state_d = ST_EMIT;
      ST_EMIT:      state_d = sts_i.emit_last ? ST_IDLE : ST_SCAN_INIT;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_GEN_RD:    cmd_o.rd_pair   = 1'b1;
      ST_GEN_SQ:    cmd_o.sq_step   = 1'b1;
      ST_GEN_WR:    cmd_o.pair_wr   = 1'b1;
      ST_SCAN_INIT: cmd_o.scan_clr  = 1'b1;
      ST_SCAN:      cmd_o.scan_run  = 1'b1;
      ST_FETCH:     cmd_o.fetch     = 1'b1;
      ST_ROOT:      cmd_o.root_step = 1'b1;
      ST_EMIT:      cmd_o.emit      = 1'b1;
      default:      cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

FILE: rtl/pairwise_distance_sorter_top.sv
// pairwise_distance_sorter_top: top level of the pairwise distance sorter
// depends on pds_pkg, pds_controller and pds_datapath
`default_nettype none
// A word (one point) is taken on a rising edge with start high and busy low;
// points load at one a cycle. A word with last_point set closes the
// set: with two or more stored points busy rises and the run begins. Points
// past MAX_POINTS are dropped. Each pair is generated by reading both points,
// squaring and summing the axis differences on one shared multiplier, one axis
// a cycle, and writing the pair store. Each result then takes a scan set-up,
// a scan of the pair store at one entry a cycle, a fetch, a bit-serial square
// root of COORD_BITS + 9 result bits and an emit. Results appear in descending
// distance, ties in generation order, each for exactly one cycle with
// result_valid_o high; the receiver cannot stall them and must take every
// word as it comes.
module pairwise_distance_sorter_top import pds_pkg::*; #(
  parameter int MAX_POINTS = 8,
  parameter int COORD_BITS = 11
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [COORD_BITS-1:0]  coord_x_i,
  input  wire logic [COORD_BITS-1:0]  coord_y_i,
  input  wire logic [COORD_BITS-1:0]  coord_z_i,
  input  wire logic                   last_point_i,
  output logic                        result_valid_o,
  output logic [COORD_BITS-1:0]       first_x_o,
  output logic [COORD_BITS-1:0]       first_y_o,
  output logic [COORD_BITS-1:0]       first_z_o,
  output logic [COORD_BITS-1:0]       second_x_o,
  output logic [COORD_BITS-1:0]       second_y_o,
  output logic [COORD_BITS-1:0]       second_z_o,
  output logic [2*COORD_BITS+1:0]     dist_squared_o,
  output logic [COORD_BITS+8:0]       distance_fixed_o,
  output logic                        last_pair_o
);

  cmd_t cmd;
  sts_t sts;
  logic load;

  // a word is taken only while the sequencer is idle
  assign load = start && !busy;

  pds_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  pds_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (load),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .coord_z_i        (coord_z_i),
    .last_point_i     (last_point_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_valid_o   (result_valid_o),
    .first_x_o        (first_x_o),
    .first_y_o        (first_y_o),
    .first_z_o        (first_z_o),
    .second_x_o       (second_x_o),
    .second_y_o       (second_y_o),
    .second_z_o       (second_z_o),
    .dist_squared_o   (dist_squared_o),
    .distance_fixed_o (distance_fixed_o),
    .last_pair_o      (last_pair_o)
  );

  // a result word only follows the emit cycle of a run
  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result outside a run");

  // emits are always parted by a new scan
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("consecutive result words");

  // the final pair ends the run
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_pair_o) |-> !busy) else $error("run outlives last pair");

endmodule
`default_nettype wire
